@@ sv/irsc_pkg.sv @@
`timescale 1ns / 1ps

package irsc_pkg;

    // Number of basic interval relations, and one set of them as a bit mask.
    localparam int RelCount = 13;

    typedef logic [RelCount-1:0] rel_set_t;

    // Basic relations in bit order.
    localparam rel_set_t REL_EQ = 13'h0001;  // equal
    localparam rel_set_t REL_BF = 13'h0002;  // before
    localparam rel_set_t REL_DU = 13'h0004;  // during
    localparam rel_set_t REL_OV = 13'h0008;  // overlaps
    localparam rel_set_t REL_ME = 13'h0010;  // meets
    localparam rel_set_t REL_ST = 13'h0020;  // starts
    localparam rel_set_t REL_FN = 13'h0040;  // finishes
    localparam rel_set_t REL_AF = 13'h0080;  // after
    localparam rel_set_t REL_CO = 13'h0100;  // contains
    localparam rel_set_t REL_OB = 13'h0200;  // overlapped-by
    localparam rel_set_t REL_MB = 13'h0400;  // met-by
    localparam rel_set_t REL_SB = 13'h0800;  // started-by
    localparam rel_set_t REL_FB = 13'h1000;  // finished-by

    // Disjunctions that recur in the composition table.
    localparam rel_set_t REL_ANY   = '1;
    localparam rel_set_t REL_LOW5  = REL_BF | REL_OV | REL_ME | REL_DU | REL_ST;
    localparam rel_set_t REL_HIGH5 = REL_AF | REL_OB | REL_MB | REL_DU | REL_FN;
    localparam rel_set_t REL_LOWC  = REL_BF | REL_OV | REL_ME | REL_CO | REL_FB;
    localparam rel_set_t REL_HIGHC = REL_AF | REL_OB | REL_MB | REL_CO | REL_SB;
    localparam rel_set_t REL_MID   = REL_OV | REL_OB | REL_DU | REL_ST | REL_FN
                                   | REL_CO | REL_SB | REL_FB | REL_EQ;
    localparam rel_set_t REL_ODS   = REL_OV | REL_DU | REL_ST;
    localparam rel_set_t REL_OCF   = REL_OV | REL_CO | REL_FB;
    localparam rel_set_t REL_BCS   = REL_OB | REL_CO | REL_SB;
    localparam rel_set_t REL_BDF   = REL_OB | REL_DU | REL_FN;
    localparam rel_set_t REL_BOM   = REL_BF | REL_OV | REL_ME;
    localparam rel_set_t REL_AOM   = REL_AF | REL_OB | REL_MB;
    localparam rel_set_t REL_FFE   = REL_FN | REL_FB | REL_EQ;
    localparam rel_set_t REL_SSE   = REL_ST | REL_SB | REL_EQ;

    // Composition table: row is the A-to-B relation, column the B-to-C relation.
    localparam rel_set_t COMPOSE_TABLE [RelCount][RelCount] = '{
        '{REL_EQ, REL_BF, REL_DU, REL_OV, REL_ME, REL_ST, REL_FN,
          REL_AF, REL_CO, REL_OB, REL_MB, REL_SB, REL_FB},
        '{REL_BF, REL_BF, REL_LOW5, REL_BF, REL_BF, REL_BF, REL_LOW5,
          REL_ANY, REL_BF, REL_LOW5, REL_LOW5, REL_BF, REL_BF},
        '{REL_DU, REL_BF, REL_DU, REL_LOW5, REL_BF, REL_DU, REL_DU,
          REL_AF, REL_ANY, REL_HIGH5, REL_AF, REL_HIGH5, REL_LOW5},
        '{REL_OV, REL_BF, REL_ODS, REL_BOM, REL_BF, REL_OV, REL_ODS,
          REL_HIGHC, REL_LOWC, REL_MID, REL_BCS, REL_OCF, REL_BOM},
        '{REL_ME, REL_BF, REL_ODS, REL_BF, REL_BF, REL_ME, REL_ODS,
          REL_HIGHC, REL_BF, REL_ODS, REL_FFE, REL_ME, REL_BF},
        '{REL_ST, REL_BF, REL_DU, REL_BOM, REL_BF, REL_ST, REL_DU,
          REL_AF, REL_LOWC, REL_BDF, REL_MB, REL_SSE, REL_BOM},
        '{REL_FN, REL_BF, REL_DU, REL_ODS, REL_ME, REL_DU, REL_FN,
          REL_AF, REL_HIGHC, REL_AOM, REL_AF, REL_AOM, REL_FFE},
        '{REL_AF, REL_ANY, REL_HIGH5, REL_HIGH5, REL_HIGH5, REL_HIGH5, REL_AF,
          REL_AF, REL_AF, REL_AF, REL_AF, REL_AF, REL_AF},
        '{REL_CO, REL_LOWC, REL_MID, REL_OCF, REL_OCF, REL_OCF, REL_BCS,
          REL_HIGHC, REL_CO, REL_BCS, REL_BCS, REL_CO, REL_CO},
        '{REL_OB, REL_LOWC, REL_BDF, REL_MID, REL_OCF, REL_BDF, REL_OB,
          REL_AF, REL_HIGHC, REL_AOM, REL_AF, REL_AOM, REL_BCS},
        '{REL_MB, REL_LOWC, REL_BDF, REL_BDF, REL_SSE, REL_BDF, REL_MB,
          REL_AF, REL_AF, REL_AF, REL_AF, REL_AF, REL_MB},
        '{REL_SB, REL_LOWC, REL_BDF, REL_OCF, REL_OCF, REL_SSE, REL_OB,
          REL_AF, REL_CO, REL_OB, REL_MB, REL_SB, REL_CO},
        '{REL_FB, REL_BF, REL_ODS, REL_OV, REL_ME, REL_OV, REL_FFE,
          REL_HIGHC, REL_CO, REL_BCS, REL_BCS, REL_CO, REL_FB}
    };

endpackage

@@ sv/irsc_req_if.sv @@
`timescale 1ns / 1ps

interface irsc_req_if;
    import irsc_pkg::*;

    logic     valid;
    logic     ready;
    rel_set_t first_relations;
    rel_set_t second_relations;

    modport source (output valid, output first_relations, output second_relations,
                    input ready);
    modport sink (input valid, input first_relations, input second_relations,
                  output ready);
endinterface

@@ sv/irsc_rsp_if.sv @@
`timescale 1ns / 1ps

interface irsc_rsp_if;
    import irsc_pkg::*;

    logic     valid;
    logic     ready;
    rel_set_t composed_relations;

    modport source (output valid, output composed_relations, input ready);
    modport sink (input valid, input composed_relations, output ready);
endinterface

@@ sv/irsc_compose.sv @@
`timescale 1ns / 1ps

module irsc_compose (
    input  irsc_pkg::rel_set_t first_relations,
    input  irsc_pkg::rel_set_t second_relations,
    output irsc_pkg::rel_set_t composed_relations
);
    import irsc_pkg::*;

    // AND-OR plane: every pair of set bits contributes its table entry.
    // An empty set on either side selects no entry and gives an empty result.
    always_comb
    begin
        composed_relations = '0;
        for (int i = 0; i < RelCount; i++)
        begin
            for (int j = 0; j < RelCount; j++)
            begin
                if (first_relations[i] && second_relations[j])
                begin
                    composed_relations = composed_relations | COMPOSE_TABLE[i][j];
                end
            end
        end
    end

endmodule

@@ sv/interval_relation_set_compose.sv @@
// Channel | Direction | Payload
// req     | sink      | first_relations[12:0], second_relations[12:0]
// rsp     | source    | composed_relations[12:0]
//
// A request is held in the input register, where the composition plane
// works on it, and its result is then captured in the result register,
// from which it leaves when rsp accepts it.
// A new request is accepted in every cycle while rsp keeps up.
// Reset clears both valid flags; payload registers are not reset.
// When both registers are full and rsp stalls, req.ready drops in that cycle.
`timescale 1ns / 1ps

module interval_relation_set_compose (
    input logic     clk,
    input logic     rst_n,
    irsc_req_if.sink   req,
    irsc_rsp_if.source rsp
);
    import irsc_pkg::*;

    logic     in_valid_reg;
    rel_set_t first_reg;
    rel_set_t second_reg;
    logic     out_valid_reg;
    rel_set_t result_reg;
    rel_set_t result_next;
    logic     out_load;
    logic     in_load;

    // The result register takes a new value when empty or being drained;
    // the input register likewise when its content moves on.
    assign out_load  = !out_valid_reg || rsp.ready;
    assign in_load   = !in_valid_reg || out_load;
    assign req.ready = in_load;

    irsc_compose u_compose (
        .first_relations    (first_reg),
        .second_relations   (second_reg),
        .composed_relations (result_next)
    );

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                in_valid_reg <= req.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_load && req.valid)
        begin
            first_reg  <= req.first_relations;
            second_reg <= req.second_relations;
        end
        if (out_load && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.composed_relations = result_reg;

endmodule

@@ bench/interval_relation_set_compose_tb.sv @@
`timescale 1ns / 1ps

module interval_relation_set_compose_tb;
    import irsc_pkg::*;

    // Cycles without any accepted request or result before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to wait after the last result.
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_REQUESTS = 480;

    // Recurring unions of basic relations, used to spell out the composition table.
    localparam rel_set_t ALL_REL = '1;
    localparam rel_set_t PRE_DU  = REL_BF | REL_OV | REL_ME | REL_DU | REL_ST;
    localparam rel_set_t POST_DU = REL_AF | REL_OB | REL_MB | REL_DU | REL_FN;
    localparam rel_set_t PRE_CO  = REL_BF | REL_OV | REL_ME | REL_CO | REL_FB;
    localparam rel_set_t POST_CO = REL_AF | REL_OB | REL_MB | REL_CO | REL_SB;
    localparam rel_set_t OVL_ANY = REL_OV | REL_OB | REL_DU | REL_ST | REL_FN
                                 | REL_CO | REL_SB | REL_FB | REL_EQ;
    localparam rel_set_t O_D_S   = REL_OV | REL_DU | REL_ST;
    localparam rel_set_t O_C_F   = REL_OV | REL_CO | REL_FB;
    localparam rel_set_t OB_C_S  = REL_OB | REL_CO | REL_SB;
    localparam rel_set_t OB_D_F  = REL_OB | REL_DU | REL_FN;
    localparam rel_set_t B_O_M   = REL_BF | REL_OV | REL_ME;
    localparam rel_set_t A_OB_MB = REL_AF | REL_OB | REL_MB;
    localparam rel_set_t F_FB_E  = REL_FN | REL_FB | REL_EQ;
    localparam rel_set_t S_SB_E  = REL_ST | REL_SB | REL_EQ;

    // Allen composition: row is the A-to-B relation, column the B-to-C relation.
    localparam rel_set_t ALLEN_COMPOSE [RelCount][RelCount] = '{
        '{REL_EQ, REL_BF, REL_DU, REL_OV, REL_ME, REL_ST, REL_FN,
          REL_AF, REL_CO, REL_OB, REL_MB, REL_SB, REL_FB},
        '{REL_BF, REL_BF, PRE_DU, REL_BF, REL_BF, REL_BF, PRE_DU,
          ALL_REL, REL_BF, PRE_DU, PRE_DU, REL_BF, REL_BF},
        '{REL_DU, REL_BF, REL_DU, PRE_DU, REL_BF, REL_DU, REL_DU,
          REL_AF, ALL_REL, POST_DU, REL_AF, POST_DU, PRE_DU},
        '{REL_OV, REL_BF, O_D_S, B_O_M, REL_BF, REL_OV, O_D_S,
          POST_CO, PRE_CO, OVL_ANY, OB_C_S, O_C_F, B_O_M},
        '{REL_ME, REL_BF, O_D_S, REL_BF, REL_BF, REL_ME, O_D_S,
          POST_CO, REL_BF, O_D_S, F_FB_E, REL_ME, REL_BF},
        '{REL_ST, REL_BF, REL_DU, B_O_M, REL_BF, REL_ST, REL_DU,
          REL_AF, PRE_CO, OB_D_F, REL_MB, S_SB_E, B_O_M},
        '{REL_FN, REL_BF, REL_DU, O_D_S, REL_ME, REL_DU, REL_FN,
          REL_AF, POST_CO, A_OB_MB, REL_AF, A_OB_MB, F_FB_E},
        '{REL_AF, ALL_REL, POST_DU, POST_DU, POST_DU, POST_DU, REL_AF,
          REL_AF, REL_AF, REL_AF, REL_AF, REL_AF, REL_AF},
        '{REL_CO, PRE_CO, OVL_ANY, O_C_F, O_C_F, O_C_F, OB_C_S,
          POST_CO, REL_CO, OB_C_S, OB_C_S, REL_CO, REL_CO},
        '{REL_OB, PRE_CO, OB_D_F, OVL_ANY, O_C_F, OB_D_F, REL_OB,
          REL_AF, POST_CO, A_OB_MB, REL_AF, A_OB_MB, OB_C_S},
        '{REL_MB, PRE_CO, OB_D_F, OB_D_F, S_SB_E, OB_D_F, REL_MB,
          REL_AF, REL_AF, REL_AF, REL_AF, REL_AF, REL_MB},
        '{REL_SB, PRE_CO, OB_D_F, O_C_F, O_C_F, S_SB_E, REL_OB,
          REL_AF, REL_CO, REL_OB, REL_MB, REL_SB, REL_CO},
        '{REL_FB, REL_BF, O_D_S, REL_OV, REL_ME, REL_OV, F_FB_E,
          POST_CO, REL_CO, OB_C_S, OB_C_S, REL_CO, REL_FB}
    };

    // Receiver stall behavior, chosen afresh for each stretch of cycles.
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_t;

    logic clk;
    logic rst_n;

    irsc_req_if req ();
    irsc_rsp_if rsp ();

    interval_relation_set_compose dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    rel_set_t pending_compositions [$];
    int       requests_sent     = 0;
    int       results_checked   = 0;
    int       error_count       = 0;
    int       burst_left        = 0;
    bit       long_hold_request = 1'b0;

    // Union of the table entries over every pair of set bits.
    function automatic rel_set_t compose_relation_sets(input rel_set_t first,
                                                       input rel_set_t second);
        rel_set_t acc = '0;
        for (int i = 0; i < RelCount; i++) begin
            for (int j = 0; j < RelCount; j++) begin
                if (first[i] && second[j]) begin
                    acc |= ALLEN_COMPOSE[i][j];
                end
            end
        end
        return acc;
    endfunction

    // Offers one request, with a random gap at the start of each burst, and
    // records the expected composition once it is accepted.
    task automatic send_request(input rel_set_t first, input rel_set_t second);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req.valid            <= 1'b1;
        req.first_relations  <= first;
        req.second_relations <= second;
        @(posedge clk);
        while (req.ready !== 1'b1) begin
            @(posedge clk);
        end
        pending_compositions.push_back(compose_relation_sets(first, second));
        requests_sent++;
    endtask

    // Drops valid after the last request of a test.
    task automatic idle_request();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        while (pending_compositions.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // An empty set on either side must give an empty result.
    task automatic test_empty_sets();
        send_request('0, '0);
        send_request('0, ALL_REL);
        send_request(ALL_REL, '0);
        send_request('0, REL_BF);
        send_request(REL_FB, '0);
        idle_request();
    endtask

    // Lowest and highest relation bits, alone and with full sets.
    task automatic test_extreme_sets();
        send_request(ALL_REL, ALL_REL);
        send_request(REL_EQ, REL_EQ);
        send_request(REL_FB, REL_FB);
        send_request(REL_EQ, ALL_REL);
        send_request(ALL_REL, REL_EQ);
        send_request(REL_EQ, REL_FB);
        send_request(REL_FB, REL_EQ);
        idle_request();
    endtask

    // Table entries that are easy to get wrong, plus a few full-set entries.
    task automatic test_notable_entries();
        send_request(REL_FN, REL_ST);
        send_request(REL_FN, REL_FN);
        send_request(REL_FB, REL_AF);
        send_request(REL_BF, REL_AF);
        send_request(REL_AF, REL_BF);
        send_request(REL_DU, REL_CO);
        send_request(REL_OV, REL_OB);
        send_request(REL_ST | REL_FN, REL_ST | REL_FN);
        idle_request();
    endtask

    // Mix of single-relation pairs, sparse sets, full random sets, empty sets and full vs single sets.
    task automatic test_random_compositions(input int count);
        rel_set_t first;
        rel_set_t second;
        int       pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                first  = rel_set_t'(1) << $urandom_range(0, RelCount - 1);
                second = rel_set_t'(1) << $urandom_range(0, RelCount - 1);
            end else if (pick < 60) begin
                first  = rel_set_t'($urandom() & $urandom() & $urandom());
                second = rel_set_t'($urandom() & $urandom() & $urandom());
            end else if (pick < 85) begin
                first  = rel_set_t'($urandom());
                second = rel_set_t'($urandom());
            end else if (pick < 92) begin
                first  = rel_set_t'($urandom());
                second = '0;
                if ($urandom_range(0, 1) == 1) begin
                    second = first;
                    first  = '0;
                end
            end else begin
                first  = ALL_REL;
                second = rel_set_t'(1) << $urandom_range(0, RelCount - 1);
                if ($urandom_range(0, 1) == 1) begin
                    first  = second;
                    second = ALL_REL;
                end
            end
            send_request(first, second);
        end
        idle_request();
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so both pipeline registers fill and the input stalls.
    task automatic test_backpressure();
        long_hold_request = 1'b1;
        burst_left = 40;
        for (int n = 0; n < 20; n++) begin
            send_request(rel_set_t'($urandom()), rel_set_t'($urandom()));
        end
        idle_request();
    endtask

    // The sender waits for every result before it goes on.
    task automatic test_drain_pause();
        for (int n = 0; n < 12; n++) begin
            send_request(rel_set_t'($urandom()), rel_set_t'($urandom()));
        end
        idle_request();
        wait_for_drain();
        for (int n = 0; n < 12; n++) begin
            send_request(rel_set_t'($urandom()), rel_set_t'($urandom()));
        end
        idle_request();
    endtask

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever begin
            #2 clk = ~clk;
        end
    end

    // Receiver: long hold-off on demand, otherwise stretches of stall patterns.
    initial begin
        stall_mode_t mode;
        int          stretch;
        int          phase;
        int          hold_left;
        mode      = STALL_NONE;
        stretch   = 0;
        phase     = 0;
        hold_left = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp.ready <= 1'b0;
            end else if (long_hold_request) begin
                long_hold_request = 1'b0;
                hold_left = $urandom_range(60, 90);
                rsp.ready <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode    = stall_mode_t'($urandom_range(0, 3));
                    stretch = $urandom_range(8, 40);
                    phase   = 0;
                end
                stretch--;
                phase++;
                case (mode)
                    STALL_NONE:     rsp.ready <= 1'b1;
                    STALL_RANDOM:   rsp.ready <= 1'($urandom_range(0, 1));
                    STALL_PERIODIC: rsp.ready <= (phase % 3) != 0;
                    default:        rsp.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Compare each accepted result with the oldest expected composition.
    initial begin
        rel_set_t expected;
        forever begin
            @(posedge clk);
            if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
                if (pending_compositions.size() == 0) begin
                    $display("%0t: unexpected result composed_relations=%h",
                             $time, rsp.composed_relations);
                    error_count++;
                end else begin
                    expected = pending_compositions.pop_front();
                    results_checked++;
                    if (rsp.composed_relations !== expected) begin
                        $display("%0t: composed_relations mismatch: expected %h, actual %h",
                                 $time, expected, rsp.composed_relations);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: counts cycles with work outstanding but no handshake.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req.valid === 1'b1 && req.ready === 1'b1)
                || (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
                quiet_cycles = 0;
            end else if (req.valid === 1'b1 || pending_compositions.size() != 0) begin
                quiet_cycles++;
            end
        end
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending_compositions.size());
        $display("interval_relation_set_compose_tb NOT OK");
        $finish;
    end

    // Reset, then the tests in turn.
    initial begin
        rst_n                = 1'b0;
        req.valid            <= 1'b0;
        req.first_relations  <= '0;
        req.second_relations <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_sets();
        test_extreme_sets();
        test_notable_entries();
        test_backpressure();
        test_random_compositions(RANDOM_REQUESTS / 2);
        test_drain_pause();
        test_random_compositions(RANDOM_REQUESTS / 2);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_compositions.size() != 0) begin
            $display("%0t: %0d expected results never arrived",
                     $time, pending_compositions.size());
            error_count++;
        end

        $display("Composed %0d request pairs and checked %0d results, with %0d mismatches.",
                 requests_sent, results_checked, error_count);
        $display("Covered empty and full sets, single-relation pairs, %s",
                 "a long receiver hold-off and a full drain.");
        if (error_count == 0) begin
            $display("interval_relation_set_compose_tb OK");
        end else begin
            $display("interval_relation_set_compose_tb NOT OK");
        end
        $finish;
    end

endmodule
